FILE: design/idbc_pkg.sv
// Package for the image difference box checker.
// Widths, register indexes, verdict codes and the record and result layouts.
// No dependencies.
package idbc_pkg;

  localparam int MAX_DIM         = 4096;
  localparam int POS_W           = 12;
  localparam int DIM_W           = 13;
  localparam int SUM_W           = 17;
  localparam int CNT_W           = 25;
  localparam int PIX_W           = 32;
  localparam int BOX_W           = 64;
  localparam int BOX_FIELD_W     = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int NUM_BOX_REGS    = 4;
  localparam int NUM_BOXES_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int IN_DATA_W       = 64;
  localparam int OUT_DATA_W      = 104;
  localparam int OUT_PAD_W       = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_BOXES_IN_USE = 3'd2,
    REG_BOX_0        = 3'd3,
    REG_BOX_1        = 3'd4,
    REG_BOX_2        = 3'd5,
    REG_BOX_3        = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_SAME    = 2'd0,
    VERDICT_INSIDE  = 2'd1,
    VERDICT_OUTSIDE = 2'd2
  } verdict_t;

  // one classified pixel, front to back
  typedef struct packed {
    logic             diff;
    logic             outside;
    logic             last;
    logic             any_box;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
  } rec_t;

  // result beat, last field in the lowest bits
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [1:0]           verdict;
    logic [POS_W-1:0]     box_bottom;
    logic [POS_W-1:0]     box_top;
    logic [POS_W-1:0]     box_right;
    logic [POS_W-1:0]     box_left;
    logic [CNT_W-1:0]     outside_count;
    logic [CNT_W-1:0]     differing_count;
  } result_t;

endpackage

FILE: design/idbc_front.sv
// Front end: configuration registers, raster position counters and per-pixel
// classification against the allowed boxes. Depends on idbc_pkg.
module idbc_front #(
  parameter int NUM_BOXES = idbc_pkg::NUM_BOXES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [idbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [idbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             queue_full,
  input  logic [idbc_pkg::PIX_W-1:0]       before_pixel,
  input  logic [idbc_pkg::PIX_W-1:0]       after_pixel,
  output logic                             in_ready,
  output logic                             push,
  output idbc_pkg::rec_t                   rec
);

  localparam int POS_W = idbc_pkg::POS_W;
  localparam int DIM_W = idbc_pkg::DIM_W;
  localparam int SUM_W = idbc_pkg::SUM_W;
  localparam int FW    = idbc_pkg::BOX_FIELD_W;

  logic [DIM_W-1:0]          frame_width;
  logic [DIM_W-1:0]          frame_height;
  logic [2:0]                boxes_in_use;
  logic [idbc_pkg::BOX_W-1:0] boxes [NUM_BOXES];

  logic [POS_W-1:0] column;
  logic [POS_W-1:0] row;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic             col_wrap;
  logic             row_wrap;
  logic             in_any_box;

  function automatic logic in_box(input logic [idbc_pkg::BOX_W-1:0] box,
                                  input logic [POS_W-1:0] x,
                                  input logic [POS_W-1:0] y);
    logic [SUM_W-1:0] xe;
    logic [SUM_W-1:0] ye;
    logic [SUM_W-1:0] bx;
    logic [SUM_W-1:0] by;
    logic [SUM_W-1:0] bw;
    logic [SUM_W-1:0] bh;
    xe = SUM_W'(x);
    ye = SUM_W'(y);
    bx = SUM_W'(box[FW-1:0]);
    by = SUM_W'(box[2*FW-1:FW]);
    bw = SUM_W'(box[3*FW-1:2*FW]);
    bh = SUM_W'(box[4*FW-1:3*FW]);
    return (xe >= bx) && (xe < bx + bw) && (ye >= by) && (ye < by + bh);
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > DIM_W'(idbc_pkg::MAX_DIM)) begin
      return DIM_W'(idbc_pkg::MAX_DIM);
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(idbc_pkg::MAX_DIM);
      frame_height <= DIM_W'(idbc_pkg::MAX_DIM);
      boxes_in_use <= '0;
      for (int b = 0; b < NUM_BOXES; b++) begin
        boxes[b] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        idbc_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        idbc_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        idbc_pkg::REG_BOXES_IN_USE: boxes_in_use <= cfg_data[2:0];
        default: begin
          for (int b = 0; b < NUM_BOXES; b++) begin
            if (b < idbc_pkg::NUM_BOX_REGS &&
                int'(cfg_index) == int'(idbc_pkg::REG_BOX_0) + b) begin
              boxes[b] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    w_eff      = clamp_dim(frame_width);
    h_eff      = clamp_dim(frame_height);
    col_wrap   = (DIM_W'(column) + DIM_W'(1)) >= w_eff;
    row_wrap   = (DIM_W'(row) + DIM_W'(1)) >= h_eff;
    in_any_box = 1'b0;
    for (int b = 0; b < NUM_BOXES; b++) begin
      // boxes_in_use above NUM_BOXES simply enables all of them
      if (b < int'(boxes_in_use) && in_box(boxes[b], column, row)) begin
        in_any_box = 1'b1;
      end
    end
  end

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    rec.diff    = before_pixel != after_pixel;
    rec.outside = (before_pixel != after_pixel) && !in_any_box;
    rec.last    = col_wrap && row_wrap;
    rec.any_box = boxes_in_use != '0;
    rec.column  = column;
    rec.row     = row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (push) begin
      if (col_wrap) begin
        column <= '0;
        row    <= row_wrap ? '0 : row + POS_W'(1);
      end else begin
        column <= column + POS_W'(1);
      end
    end
  end

endmodule

FILE: design/idbc_queue.sv
// Short queue of classified pixel records between front and back.
// Depends on idbc_pkg.
module idbc_queue #(
  parameter int DEPTH = idbc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  idbc_pkg::rec_t wr_rec,
  input  logic           pop,
  output idbc_pkg::rec_t rd_rec,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  idbc_pkg::rec_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = count == CNT_W'(DEPTH);
  assign empty  = count == '0;
  assign rd_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: design/idbc_back.sv
// Back end: per-frame totals and bounding box, and the result register.
// Depends on idbc_pkg.
module idbc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              empty,
  input  idbc_pkg::rec_t                    rec,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [idbc_pkg::OUT_DATA_W-1:0]   out_data
);

  localparam int POS_W = idbc_pkg::POS_W;
  localparam int CNT_W = idbc_pkg::CNT_W;

  logic [CNT_W-1:0] diff_total;
  logic [CNT_W-1:0] outside_total;
  logic [POS_W-1:0] min_column;
  logic [POS_W-1:0] min_row;
  logic [POS_W-1:0] max_column;
  logic [POS_W-1:0] max_row;

  logic [CNT_W-1:0] diff_next;
  logic [CNT_W-1:0] outside_next;
  logic [POS_W-1:0] min_column_next;
  logic [POS_W-1:0] min_row_next;
  logic [POS_W-1:0] max_column_next;
  logic [POS_W-1:0] max_row_next;
  idbc_pkg::result_t result_next;
  idbc_pkg::result_t result;

  assign pop = !empty && (!rec.last || !out_valid || out_ready);

  always_comb begin
    diff_next       = diff_total + CNT_W'(rec.diff);
    outside_next    = outside_total + CNT_W'(rec.outside);
    min_column_next = (rec.diff && rec.column < min_column) ? rec.column : min_column;
    min_row_next    = (rec.diff && rec.row < min_row) ? rec.row : min_row;
    max_column_next = (rec.diff && rec.column > max_column) ? rec.column : max_column;
    max_row_next    = (rec.diff && rec.row > max_row) ? rec.row : max_row;

    result_next                 = '0;
    result_next.differing_count = diff_next;
    result_next.outside_count   = outside_next;
    if (diff_next != '0) begin
      result_next.box_left   = min_column_next;
      result_next.box_right  = max_column_next;
      result_next.box_top    = min_row_next;
      result_next.box_bottom = max_row_next;
      result_next.verdict    = (outside_next == '0 && rec.any_box) ?
                               idbc_pkg::VERDICT_INSIDE : idbc_pkg::VERDICT_OUTSIDE;
    end else begin
      result_next.verdict    = idbc_pkg::VERDICT_SAME;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_total    <= '0;
      outside_total <= '0;
      min_column    <= '1;
      min_row       <= '1;
      max_column    <= '0;
      max_row       <= '0;
    end else if (pop) begin
      if (rec.last) begin
        diff_total    <= '0;
        outside_total <= '0;
        min_column    <= '1;
        min_row       <= '1;
        max_column    <= '0;
        max_row       <= '0;
      end else begin
        diff_total    <= diff_next;
        outside_total <= outside_next;
        min_column    <= min_column_next;
        min_row       <= min_row_next;
        max_column    <= max_column_next;
        max_row       <= max_row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && rec.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && rec.last) begin
      result <= result_next;
    end
  end

  assign out_data = result;

endmodule

FILE: design/image_difference_box_checker.sv
// Path: the last pixel beat of a frame passes through a queue entry and then the result register to its result beat.
// Throughput: one pixel pair per cycle; a waiting result stalls the back end on the
// next frame's last pixel, and s_tready drops once the queue (four entries by default) is full.
// Reset (rst, synchronous): config to defaults, counters and queue cleared.
// Top level of the image difference box checker; depends on idbc_pkg,
// idbc_front, idbc_queue and idbc_back.
module image_difference_box_checker #(
  parameter int NUM_BOXES   = idbc_pkg::NUM_BOXES_DEF,
  parameter int QUEUE_DEPTH = idbc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [idbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [idbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // before_pixel[31:0], after_pixel[63:32]
  input  logic [idbc_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // differing_count[24:0], outside_count[49:25], box_left[61:50],
  // box_right[73:62], box_top[85:74], box_bottom[97:86], verdict[99:98]
  output logic [idbc_pkg::OUT_DATA_W-1:0]   m_tdata
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  idbc_pkg::rec_t wr_rec;
  idbc_pkg::rec_t rd_rec;

  idbc_front #(.NUM_BOXES(NUM_BOXES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (s_tvalid),
    .queue_full   (full),
    .before_pixel (s_tdata[idbc_pkg::PIX_W-1:0]),
    .after_pixel  (s_tdata[2*idbc_pkg::PIX_W-1:idbc_pkg::PIX_W]),
    .in_ready     (s_tready),
    .push         (push),
    .rec          (wr_rec)
  );

  idbc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (rd_rec),
    .full   (full),
    .empty  (empty)
  );

  idbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .rec       (rd_rec),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

FILE: design/idbc_checker.sv
// Port-level checks for the image difference box checker, bound to the top.
// Depends on idbc_pkg and image_difference_box_checker.
module idbc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [idbc_pkg::OUT_DATA_W-1:0]   m_tdata
);

  idbc_pkg::result_t res;
  assign res = m_tdata;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.verdict == idbc_pkg::VERDICT_SAME ||
                 res.verdict == idbc_pkg::VERDICT_INSIDE ||
                 res.verdict == idbc_pkg::VERDICT_OUTSIDE)
    else $error("bad verdict code");

  a_same_iff_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((res.verdict == idbc_pkg::VERDICT_SAME) == (res.differing_count == '0)))
    else $error("verdict disagrees with differing count");

  a_outside_le: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.outside_count <= res.differing_count)
    else $error("outside count exceeds differing count");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.box_left <= res.box_right && res.box_top <= res.box_bottom)
    else $error("bounding box inverted");

endmodule

bind image_difference_box_checker idbc_checker u_idbc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
